### hdl/streaming_top_k_select_assert.svh
// Assertion macros for the top-k selector modules.
// Depends on nothing; included by modules that assert.
`ifndef STREAMING_TOP_K_SELECT_ASSERT_SVH
`define STREAMING_TOP_K_SELECT_ASSERT_SVH

// Implication checked every clock outside reset.
`define TKS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TKS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### hdl/tks_pkg.sv
// Package for the top-k selector: types and constants.
// Depends on nothing.
package tks_pkg;
    localparam int MAX_KEEP_DEF = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_LARGEST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 8'd1;
    localparam logic [6:0] KEEP_COUNT_RST = 7'd16;

    typedef enum logic [1:0] {
        t_ST_INSERT = 2'd0,
        t_ST_EMIT   = 2'd1
    } t_back_state;

    // Item as stamped with its position by the front part.
    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        position;
        logic               last;
    } t_cmd;
endpackage

### hdl/tks_if.sv
// Valid/ready channel interfaces for the top-k selector.
// Depends on nothing.
interface tks_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;
    logic              last;
    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

interface tks_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] kept_value;
    logic [31:0]       position;
    logic              final_res;
    modport source (output valid, kept_value, position, final_res, input ready);
    modport sink   (input valid, kept_value, position, final_res, output ready);
endinterface

interface tks_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/tks_front.sv
// Front part: stamps positions on items and queues them for the back part.
// Depends on tks_pkg.
module tks_front #(
    parameter int QDEPTH = tks_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic signed [31:0] i_value,
    input  logic          i_last,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output tks_pkg::t_cmd o_cmd
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    tks_pkg::t_cmd r_q [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [31:0]   r_pos, n_pos;
    logic push, pop;

    assign o_ready = (r_cnt != (AW+1)'(QDEPTH));
    assign push = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd = r_q[r_rp];

    // Advance position, saturate, restart after last
    always_comb begin
        n_pos = r_pos;
        if (push) begin
            if (i_last) n_pos = '0;
            else if (r_pos != '1) n_pos = r_pos + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_pos <= '0;
        end else begin
            r_pos <= n_pos;
            if (push) r_wp <= (r_wp == AW'(QDEPTH-1)) ? '0 : r_wp + AW'(1);
            if (pop)  r_rp <= (r_rp == AW'(QDEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= '{value: i_value, position: r_pos, last: i_last};
    end
endmodule

### hdl/tks_back.sv
// Back part: row of compare-and-shift cells, then drains results in rank order.
// Depends on tks_pkg and the assertion header.
`include "streaming_top_k_select_assert.svh"
module tks_back #(
    parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_sel_largest,
    input  logic [6:0]    i_keep_count,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  tks_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic signed [31:0] o_value,
    output logic [31:0]   o_position,
    output logic          o_final
);
    localparam int KW = $clog2(MAX_KEEP + 1);
    localparam int AW = $clog2(MAX_KEEP > 1 ? MAX_KEEP : 2);
    logic signed [31:0] r_val [MAX_KEEP];
    logic [31:0]        r_pos [MAX_KEEP];
    logic [KW-1:0]      r_fill, n_fill, r_emit, r_cnt;
    logic [KW-1:0]      k;
    tks_pkg::t_back_state r_st, n_st;
    logic [MAX_KEEP-1:0] beat;
    logic [MAX_KEEP-1:0] sfx;
    logic [MAX_KEEP:0]  sfx_up;
    logic               run_ok;
    logic               ins, take, out_take;
    logic [KW-1:0]      n_eff;
    logic               r_ov;
    logic signed [31:0] r_ovv;
    logic [31:0]        r_ovp;
    logic               r_ovf;

    assign k = (i_keep_count > 7'(MAX_KEEP)) ? KW'(MAX_KEEP) : KW'(i_keep_count);
    assign o_cmd_ready = (r_st == tks_pkg::t_ST_INSERT);
    assign take = i_cmd_valid && o_cmd_ready;

    // Compare new value against every cell
    always_comb begin
        for (int j = 0; j < MAX_KEEP; j++)
            beat[j] = i_sel_largest ? (i_cmd.value > r_val[j]) : (i_cmd.value < r_val[j]);
    end

    always_comb begin
        n_eff = (r_fill > k) ? k : r_fill;
        ins = 1'b1;
        if (n_eff == k) begin
            if (k == '0) ins = 1'b0;
            else if (!beat[AW'(k - KW'(1))]) ins = 1'b0;
            else n_eff = k - KW'(1);
        end
        n_fill = ins ? n_eff + KW'(1) : n_eff;
    end

    // Mark the unbroken run of beaten cells that ends at the last kept entry
    always_comb begin
        run_ok = 1'b1;
        for (int j = MAX_KEEP - 1; j >= 0; j--) begin
            if (KW'(j) < n_eff) run_ok = run_ok & beat[j];
            sfx[j] = (KW'(j) < n_eff) && run_ok;
        end
    end

    assign sfx_up = {sfx, 1'b0};

    // Shift cells: the marked run moves one place back, the new item fills the gap
    always_ff @(posedge i_clk) begin
        if (take && ins) begin
            for (int j = 1; j < MAX_KEEP; j++) begin
                if (sfx[j-1]) begin
                    r_val[j] <= r_val[j-1];
                    r_pos[j] <= r_pos[j-1];
                end
            end
            for (int j = 0; j < MAX_KEEP; j++) begin
                if (KW'(j) <= n_eff && !sfx_up[j] && (KW'(j) == n_eff || sfx[j])) begin
                    r_val[j] <= i_cmd.value;
                    r_pos[j] <= i_cmd.position;
                end
            end
        end
    end

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            tks_pkg::t_ST_INSERT:
                if (take && i_cmd.last && ((n_fill > k ? k : n_fill) != '0))
                    n_st = tks_pkg::t_ST_EMIT;
            tks_pkg::t_ST_EMIT:
                if (!r_ov || i_ready)
                    if (r_emit + KW'(1) == r_cnt) n_st = tks_pkg::t_ST_INSERT;
            default: n_st = tks_pkg::t_ST_INSERT;
        endcase
    end

    assign out_take = (r_st == tks_pkg::t_ST_EMIT) && (!r_ov || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tks_pkg::t_ST_INSERT;
            r_fill <= '0; r_emit <= '0; r_cnt <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (take) begin
                r_fill <= i_cmd.last ? '0 : n_fill;
                r_cnt <= (n_fill > k) ? k : n_fill;
                r_emit <= '0;
            end else if (out_take) begin
                r_emit <= r_emit + KW'(1);
            end
            if (out_take) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_ovv <= r_val[r_emit[AW-1:0]];
            r_ovp <= r_pos[r_emit[AW-1:0]];
            r_ovf <= (r_emit + KW'(1) == r_cnt);
        end
    end

    assign o_valid = r_ov;
    assign o_value = r_ovv;
    assign o_position = r_ovp;
    assign o_final = r_ovf;

    `TKS_ASSERT_IMP(a_no_take_in_emit, i_clk, i_rst_n, r_st == tks_pkg::t_ST_EMIT, !take)
    `TKS_ASSERT_IMP(a_emit_in_range, i_clk, i_rst_n, r_st == tks_pkg::t_ST_EMIT, r_emit < r_cnt)
    `TKS_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_value))
endmodule

### hdl/streaming_top_k_select.sv
// Top level of the streaming top-k selector: config registers, front and back.
// Depends on tks_pkg, tks_if, tks_front, tks_back.
//  channel | dir | payload
//  in_ch   | in  | value, last
//  out_ch  | out | kept_value, position, final_res
//  cfg_ch  | in  | index, data
// One item per cycle while no results drain; the compare-and-shift row updates
// all cells together for an insert. After a last item, min(k,count) results drain.
// Reset is synchronous and clears the fill level and position counter.
// A two-entry queue accepts up to two more items while results drain or stall.
module streaming_top_k_select #(
    parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tks_in_if.sink    in_ch,
    tks_out_if.source out_ch,
    tks_cfg_if.sink   cfg_ch
);
    logic          r_sel;
    logic [6:0]    r_keep;
    logic          cmd_valid, cmd_ready;
    tks_pkg::t_cmd cmd;

    assign cfg_ch.ready = 1'b1;

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
            r_keep <= tks_pkg::KEEP_COUNT_RST;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.index == tks_pkg::REG_SELECT_LARGEST) r_sel <= cfg_ch.data[0];
            else if (cfg_ch.index == tks_pkg::REG_KEEP_COUNT) r_keep <= cfg_ch.data[6:0];
        end
    end

    tks_front #(.QDEPTH(tks_pkg::QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_value(in_ch.value), .i_last(in_ch.last),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    tks_back #(.MAX_KEEP(MAX_KEEP)) u_back (
        .i_clk, .i_rst_n,
        .i_sel_largest(r_sel), .i_keep_count(r_keep),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_value(out_ch.kept_value), .o_position(out_ch.position),
        .o_final(out_ch.final_res)
    );
endmodule
